### src/soau_pkg.sv
`timescale 1ns / 1ps

package soau_pkg;

    localparam int SEGMENT_COUNT  = 8;
    localparam int REGISTER_COUNT = 32;
    localparam int MEMORY_BYTES   = 65536;

    localparam int RF_IDX_W = $clog2(REGISTER_COUNT);

    localparam logic [RF_IDX_W-1:0] LAR_INDEX = RF_IDX_W'(0);
    localparam logic [RF_IDX_W-1:0] MAR_INDEX = RF_IDX_W'(1);
    localparam logic [RF_IDX_W-1:0] MBR_INDEX = RF_IDX_W'(2);

    localparam int CFG_INDEX_W = 8;

    // operand type codes, descriptor bits 31:24
    localparam logic [7:0] OPT_REGISTER  = 8'h01;
    localparam logic [7:0] OPT_IMMEDIATE = 8'h02;
    localparam logic [7:0] OPT_MEMORY    = 8'h03;

    localparam logic [15:0] INVALID_BASE = 16'hFFFF;
    localparam logic [15:0] WORD_BYTES   = 16'd4;
    localparam logic [31:0] SEGMENT_RESET = 32'hFFFF_0000;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_INVALID = 2'd1;
    localparam logic [1:0] FAULT_LIMIT   = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [31:0]        operand_descriptor;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         fault;
        logic [15:0]        physical_address;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPERAND,
        ST_XLATE,
        ST_MODQ,
        ST_MODR,
        ST_MEM,
        ST_RDONE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RF_SEL_OPERAND,
        RF_SEL_LAR,
        RF_SEL_MAR,
        RF_SEL_MBR
    } rf_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    load_opnd;
        logic    load_xlate;
        logic    load_q;
        logic    load_addr;
        logic    rf_we;
        rf_sel_t rf_sel;
        logic    mem_we;
        logic    mem_re;
        logic    addr_inc;
        logic    cap_en;
        logic [1:0] byte_sel;
        logic [1:0] cap_sel;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic is_reg;
        logic is_mem;
        logic faulted;
        logic out_busy;
    } status_t;

endpackage

### src/soau_ctrl.sv
`timescale 1ns / 1ps

module soau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  soau_pkg::status_t status,
    output soau_pkg::cmd_t    cmd
);

    soau_pkg::state_t state_reg, state_next;
    logic [2:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= soau_pkg::ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.rf_sel   = soau_pkg::RF_SEL_OPERAND;
        cmd.byte_sel = cnt_reg[1:0];
        cmd.cap_sel  = 2'(cnt_reg - 3'd1);
        req_stall    = 1'b1;

        case (state_reg)
            soau_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = soau_pkg::ST_OPERAND;
                end
            end
            soau_pkg::ST_OPERAND:
            begin
                cmd.load_opnd = 1'b1;
                if (status.is_mem)
                begin
                    state_next = soau_pkg::ST_XLATE;
                end
                else
                begin
                    // register write lands here; other types need nothing more
                    cmd.rf_we  = status.is_reg && status.mode;
                    cmd.rf_sel = soau_pkg::RF_SEL_OPERAND;
                    state_next = soau_pkg::ST_FINISH;
                end
            end
            soau_pkg::ST_XLATE:
            begin
                cmd.load_xlate = 1'b1;
                state_next     = soau_pkg::ST_MODQ;
            end
            soau_pkg::ST_MODQ:
            begin
                if (status.faulted)
                begin
                    state_next = soau_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.load_q = 1'b1;
                    cmd.rf_we  = 1'b1;
                    cmd.rf_sel = soau_pkg::RF_SEL_LAR;
                    state_next = soau_pkg::ST_MODR;
                end
            end
            soau_pkg::ST_MODR:
            begin
                cmd.load_addr = 1'b1;
                cmd.rf_we     = 1'b1;
                cmd.rf_sel    = soau_pkg::RF_SEL_MAR;
                cnt_next      = 3'd0;
                state_next    = soau_pkg::ST_MEM;
            end
            soau_pkg::ST_MEM:
            begin
                if (status.mode)
                begin
                    cmd.mem_we   = 1'b1;
                    cmd.addr_inc = 1'b1;
                    cmd.rf_we    = (cnt_reg == 3'd0);
                    cmd.rf_sel   = soau_pkg::RF_SEL_MBR;
                    cnt_next     = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3)
                    begin
                        state_next = soau_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    // read data is registered and returns in the cycle after the address
                    cmd.mem_re   = (cnt_reg != 3'd4);
                    cmd.addr_inc = (cnt_reg != 3'd4);
                    cmd.cap_en   = (cnt_reg != 3'd0);
                    cnt_next     = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                    begin
                        state_next = soau_pkg::ST_RDONE;
                    end
                end
            end
            soau_pkg::ST_RDONE:
            begin
                cmd.rf_we  = 1'b1;
                cmd.rf_sel = soau_pkg::RF_SEL_MBR;
                state_next = soau_pkg::ST_FINISH;
            end
            soau_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = soau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = soau_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/soau_dp.sv
`timescale 1ns / 1ps

module soau_dp #(
    parameter int SegmentCount = soau_pkg::SEGMENT_COUNT,
    parameter int MemoryBytes  = soau_pkg::MEMORY_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  soau_pkg::req_t                     req,
    input  logic                               cfg_valid,
    input  logic [soau_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output soau_pkg::rsp_t                     rsp,
    input  soau_pkg::cmd_t                     cmd,
    output soau_pkg::status_t                  status
);

    localparam int SegIdxW = (SegmentCount > 1) ? $clog2(SegmentCount) : 1;
    localparam int MemAw   = $clog2(MemoryBytes);
    localparam longint unsigned Recip =
        ((64'd1 << 32) + 64'(MemoryBytes) - 64'd1) / 64'(MemoryBytes);
    localparam int RfW = soau_pkg::RF_IDX_W;

    soau_pkg::req_t in_reg;
    logic [31:0]    seg_table_reg [SegmentCount];
    logic [31:0]    rf_reg [soau_pkg::REGISTER_COUNT];
    logic [7:0]     mem [MemoryBytes];

    logic [31:0]       rf_val_reg;
    logic [31:0]       logical_reg;
    logic [1:0]        fault_reg;
    logic [15:0]       phys_reg;
    logic [6:0]        q_reg;
    logic [MemAw-1:0]  addr_reg;
    logic [7:0]        rdata_reg;
    logic [31:0]       word_reg;
    soau_pkg::rsp_t    out_reg;
    logic              out_valid_reg;

    logic [7:0]     op_type;
    logic [23:0]    payload;
    logic [RfW-1:0] op_idx;
    logic [31:0]    rf_rd;
    logic [31:0]    soff;

    logic [15:0]        seg;
    logic [15:0]        seg_off;
    logic [31:0]        seg_entry;
    logic [15:0]        seg_base;
    logic [15:0]        seg_size;
    logic [1:0]         fault_next;
    logic [16:0]        end_off;

    logic [38:0]        q_prod;
    logic [23:0]        rem_raw;
    logic [23:0]        rem_fix;
    logic [MemAw-1:0]   addr_next;

    logic [RfW-1:0]     rf_widx;
    logic [31:0]        rf_wdata;
    logic [7:0]         wbyte;
    soau_pkg::rsp_t     result;

    assign op_type = in_reg.operand_descriptor[31:24];
    assign payload = in_reg.operand_descriptor[23:0];
    assign op_idx  = payload[RfW-1:0];
    assign rf_rd   = rf_reg[op_idx];
    assign soff    = {{16{payload[23]}}, payload[23:8]};

    assign status.mode     = in_reg.mode;
    assign status.is_reg   = (op_type == soau_pkg::OPT_REGISTER);
    assign status.is_mem   = (op_type == soau_pkg::OPT_MEMORY);
    assign status.faulted  = (fault_reg != soau_pkg::FAULT_NONE);
    assign status.out_busy = out_valid_reg && rsp_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg <= req;
        end
    end

    // segment table, written from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SegmentCount; i++)
            begin
                seg_table_reg[i] <= soau_pkg::SEGMENT_RESET;
            end
        end
        else if (cfg_valid && (cfg_index < soau_pkg::CFG_INDEX_W'(SegmentCount)))
        begin
            seg_table_reg[cfg_index[SegIdxW-1:0]] <= cfg_data;
        end
    end

    // operand fetch and logical address
    always_ff @(posedge clk)
    begin
        if (cmd.load_opnd)
        begin
            rf_val_reg  <= rf_rd;
            logical_reg <= rf_rd + soff;
        end
    end

    // translation
    assign seg       = logical_reg[31:16];
    assign seg_off   = logical_reg[15:0];
    assign seg_entry = seg_table_reg[seg[SegIdxW-1:0]];
    assign seg_base  = seg_entry[31:16];
    assign seg_size  = seg_entry[15:0];
    assign end_off   = {1'b0, seg_off} + {1'b0, soau_pkg::WORD_BYTES};

    always_comb
    begin
        if (seg >= 16'(SegmentCount))
        begin
            fault_next = soau_pkg::FAULT_INVALID;
        end
        else if (seg_base == soau_pkg::INVALID_BASE)
        begin
            fault_next = soau_pkg::FAULT_INVALID;
        end
        else if (end_off > {1'b0, seg_size})
        begin
            fault_next = soau_pkg::FAULT_LIMIT;
        end
        else
        begin
            fault_next = soau_pkg::FAULT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_xlate)
        begin
            fault_reg <= fault_next;
            phys_reg  <= seg_base + seg_off;
        end
    end

    // physical address reduced into the memory range by reciprocal multiply
    assign q_prod  = 39'(phys_reg) * 39'(23'(Recip));
    assign rem_raw = 24'(phys_reg) - 24'(q_reg) * 24'(MemoryBytes);
    assign rem_fix = (rem_raw >= 24'(MemoryBytes)) ? rem_raw - 24'(MemoryBytes) : rem_raw;
    assign addr_next = (addr_reg == MemAw'(MemoryBytes - 1)) ? '0 : addr_reg + MemAw'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            q_reg <= q_prod[38:32];
        end
        if (cmd.load_addr)
        begin
            addr_reg <= rem_fix[MemAw-1:0];
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_next;
        end
    end

    // byte memory
    always_comb
    begin
        case (cmd.byte_sel)
            2'd0:    wbyte = in_reg.write_value[7:0];
            2'd1:    wbyte = in_reg.write_value[15:8];
            2'd2:    wbyte = in_reg.write_value[23:16];
            default: wbyte = in_reg.write_value[31:24];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr_reg] <= wbyte;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                2'd0:    word_reg[7:0]   <= rdata_reg;
                2'd1:    word_reg[15:8]  <= rdata_reg;
                2'd2:    word_reg[23:16] <= rdata_reg;
                default: word_reg[31:24] <= rdata_reg;
            endcase
        end
    end

    // register file
    always_comb
    begin
        case (cmd.rf_sel)
            soau_pkg::RF_SEL_OPERAND:
            begin
                rf_widx  = op_idx;
                rf_wdata = in_reg.write_value;
            end
            soau_pkg::RF_SEL_LAR:
            begin
                rf_widx  = soau_pkg::LAR_INDEX;
                rf_wdata = logical_reg;
            end
            soau_pkg::RF_SEL_MAR:
            begin
                rf_widx  = soau_pkg::MAR_INDEX;
                rf_wdata = {soau_pkg::WORD_BYTES, phys_reg};
            end
            default:
            begin
                rf_widx  = soau_pkg::MBR_INDEX;
                rf_wdata = in_reg.mode ? in_reg.write_value : word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < soau_pkg::REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (cmd.rf_we)
        begin
            rf_reg[rf_widx] <= rf_wdata;
        end
    end

    // result
    always_comb
    begin
        result = '0;
        case (op_type)
            soau_pkg::OPT_REGISTER:
            begin
                result.value = in_reg.mode ? 32'sd0 : rf_val_reg;
            end
            soau_pkg::OPT_IMMEDIATE:
            begin
                result.value = in_reg.mode ? 32'sd0 : {{16{payload[15]}}, payload[15:0]};
            end
            soau_pkg::OPT_MEMORY:
            begin
                result.fault = fault_reg;
                if (fault_reg == soau_pkg::FAULT_NONE)
                begin
                    result.value            = in_reg.mode ? 32'sd0 : word_reg;
                    result.physical_address = phys_reg;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### src/segmented_operand_access_unit.sv
`timescale 1ns / 1ps

// channel   signals                               direction  transfer when
// req       req_valid, req_stall, req             in         req_valid && !req_stall
// rsp       rsp_valid, rsp_stall, rsp             out        rsp_valid && !rsp_stall
// cfg       cfg_valid, cfg_ready, cfg_index/data  in         cfg_valid && cfg_ready
//
// Register, immediate and unknown operands pass OPERAND then FINISH, which loads the result
// register; a faulting memory operand adds XLATE and MODQ, a write also MODR and MEM, a read
// also RDONE: the four bytes move one per cycle through the single port of the byte memory,
// with registered read data. The next transfer is taken in the cycle after the load.
// Reset clears the register file and sets every segment entry invalid; memory is not cleared.
// One item is in flight; the next is taken while an earlier result waits under rsp_stall.

module segmented_operand_access_unit #(
    parameter int SegmentCount = soau_pkg::SEGMENT_COUNT,
    parameter int MemoryBytes  = soau_pkg::MEMORY_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  soau_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output soau_pkg::rsp_t                     rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [soau_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    soau_pkg::cmd_t    cmd;
    soau_pkg::status_t status;

    assign cfg_ready = 1'b1;

    soau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    soau_dp #(
        .SegmentCount (SegmentCount),
        .MemoryBytes  (MemoryBytes)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### dv/segmented_operand_access_unit_tb.sv
`timescale 1ns / 1ps

module segmented_operand_access_unit_tb;
    import soau_pkg::*;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [7:0] OPT_UNKNOWN_LOW  = 8'h00;
    localparam logic [7:0] OPT_UNKNOWN_HIGH = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_ENTRY_0 = '0;

    // worst case per item is a memory read plus the longest send and receive gaps; allow several times that
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 290;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 24;

    localparam logic [31:0] EXTREME_ENTRIES [7] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFE_FFFF, 32'h0000_FFFF,
        32'h0000_0004, 32'h0000_0003, SEGMENT_RESET
    };

    class operand_scoreboard;
        logic [31:0] seg_table [SEGMENT_COUNT];
        logic [31:0] regs [REGISTER_COUNT];
        logic [7:0]  mem [MEMORY_BYTES];
        bit          written [MEMORY_BYTES];
        rsp_t        pending [$];
        int          errors;

        function new();
            foreach (seg_table[i]) seg_table[i] = SEGMENT_RESET;
            foreach (regs[i]) regs[i] = '0;
            foreach (written[i]) written[i] = 1'b0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        // base register plus sign-extended offset from payload bits 23:8
        function logic [31:0] logical_address(logic [23:0] pl);
            return regs[pl[4:0]] + {{16{pl[23]}}, pl[23:8]};
        endfunction

        function logic [1:0] translate(logic [31:0] logical, output logic [15:0] phys);
            logic [15:0] base;
            logic [15:0] size;
            phys = '0;
            if (logical[31:16] >= 16'(SEGMENT_COUNT))
                return FAULT_INVALID;
            base = seg_table[logical[31:16]][31:16];
            size = seg_table[logical[31:16]][15:0];
            if (base == INVALID_BASE)
                return FAULT_INVALID;
            if ({1'b0, logical[15:0]} + {1'b0, WORD_BYTES} > {1'b0, size})
                return FAULT_LIMIT;
            phys = base + logical[15:0];
            return FAULT_NONE;
        endfunction

        function bit reads_unwritten(req_t r);
            logic [15:0] phys;
            logic [15:0] a;
            if (r.mode != MODE_READ || r.operand_descriptor[31:24] != OPT_MEMORY)
                return 1'b0;
            if (translate(logical_address(r.operand_descriptor[23:0]), phys) != FAULT_NONE)
                return 1'b0;
            for (int i = 0; i < int'(WORD_BYTES); i++)
            begin
                a = phys + 16'(i);
                if (!written[a])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_request(req_t r);
            rsp_t        e;
            logic [23:0] pl;
            logic [31:0] logical;
            logic [31:0] word;
            logic [15:0] phys;
            logic [15:0] a;
            e = '0;
            word = '0;
            pl = r.operand_descriptor[23:0];
            case (r.operand_descriptor[31:24])
                OPT_REGISTER:
                begin
                    if (r.mode == MODE_WRITE)
                        regs[pl[4:0]] = r.write_value;
                    else
                        e.value = regs[pl[4:0]];
                end
                OPT_IMMEDIATE:
                begin
                    if (r.mode == MODE_READ)
                        e.value = {{16{pl[15]}}, pl[15:0]};
                end
                OPT_MEMORY:
                begin
                    logical = logical_address(pl);
                    e.fault = translate(logical, phys);
                    if (e.fault == FAULT_NONE)
                    begin
                        e.physical_address = phys;
                        regs[LAR_INDEX] = logical;
                        regs[MAR_INDEX] = {WORD_BYTES, phys};
                        // bytes wrap around the top of memory
                        for (int i = 0; i < int'(WORD_BYTES); i++)
                        begin
                            a = phys + 16'(i);
                            if (r.mode == MODE_WRITE)
                            begin
                                mem[a] = r.write_value[8*i +: 8];
                                written[a] = 1'b1;
                            end
                            else
                                word[8*i +: 8] = mem[a];
                        end
                        regs[MBR_INDEX] = (r.mode == MODE_WRITE) ? r.write_value : word;
                        if (r.mode == MODE_READ)
                            e.value = word;
                    end
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result with nothing expected: value %h fault %0d address %h",
                                 got.value, got.fault, got.physical_address));
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value || got.fault !== want.fault ||
                got.physical_address !== want.physical_address)
                report($sformatf({"mismatch: expected value %h fault %0d address %h,",
                                  " got value %h fault %0d address %h"},
                                 want.value, want.fault, want.physical_address,
                                 got.value, got.fault, got.physical_address));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    operand_scoreboard sb;
    int cycle_count = 0;
    int taken_count = 0;
    int send_calm = 0;
    int recv_calm = 0;
    bit held_off = 1'b0;

    segmented_operand_access_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("segmented_operand_access_unit_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] memory_operand(logic [4:0] base_reg, logic [15:0] offset);
        return {OPT_MEMORY, offset, 3'b000, base_reg};
    endfunction

    function automatic logic [31:0] pick_segment_entry();
        logic [15:0] base;
        logic [15:0] size;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return EXTREME_ENTRIES[$urandom_range(0, 6)];
        if (pick == 1)
            return $urandom;
        base = 16'($urandom);
        if (base == INVALID_BASE)
            base = '0;
        size = (pick == 2) ? 16'($urandom) : 16'($urandom_range(4, 80));
        return {base, size};
    endfunction

    function automatic req_t rand_request();
        req_t        r;
        int          pick;
        int          seg;
        int          lim;
        int          base_reg;
        logic [15:0] size;
        logic [15:0] off;
        logic [15:0] jitter;
        logic [31:0] target;
        logic [31:0] delta;
        r.mode = 1'($urandom);
        r.operand_descriptor = $urandom;
        r.write_value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 7)
            return r;
        if (pick < 25)
        begin
            r.operand_descriptor[31:24] = (pick < 12) ? OPT_IMMEDIATE : OPT_REGISTER;
            return r;
        end
        r.operand_descriptor[31:24] = OPT_MEMORY;
        // random base and offset: nearly always a translation fault
        if (pick < 33)
            return r;
        seg = $urandom_range(0, SEGMENT_COUNT - 1);
        size = sb.seg_table[seg][15:0];
        lim = int'(size) - 4;
        pick = $urandom_range(0, 19);
        if (lim < 0)
            off = 16'($urandom_range(0, 7));
        else if (pick == 0)
            off = 16'(lim);
        else if (pick == 1)
            off = 16'(lim + 1);
        else if (pick < 5)
            off = 16'($urandom_range(0, lim));
        else
            off = 16'($urandom_range(0, (lim < 48) ? lim : 48));
        target = {16'(seg), off};
        base_reg = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 2)
                                              : $urandom_range(3, REGISTER_COUNT - 1);
        delta = target - sb.regs[base_reg];
        if ($signed(delta) >= -32768 && $signed(delta) <= 32767)
            r.operand_descriptor = {OPT_MEMORY, delta[15:0], r.operand_descriptor[7:5],
                                    5'(base_reg)};
        else
        begin
            // out of reach: move the base register near the target first
            jitter = 16'($urandom);
            r.mode = MODE_WRITE;
            r.operand_descriptor = {OPT_REGISTER, r.operand_descriptor[23:5], 5'(base_reg)};
            r.write_value = target - {{16{jitter[15]}}, jitter};
        end
        return r;
    endfunction

    task automatic push_item(req_t item);
        int gap;
        // never read bytes that were not stored: turn such a read into a store
        if (sb.reads_unwritten(item))
            item.mode = MODE_WRITE;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sb.take_request(item);
        taken_count++;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(logic mode, logic [31:0] descriptor, logic [31:0] wval);
        req_t r;
        r.mode = mode;
        r.operand_descriptor = descriptor;
        r.write_value = wval;
        push_item(r);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_segment_table(input logic [31:0] entries [SEGMENT_COUNT]);
        for (int i = 0; i < SEGMENT_COUNT; i++)
        begin
            cfg_index <= CFG_SEGMENT_ENTRY_0 + CFG_INDEX_W'(i);
            cfg_data  <= entries[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            sb.seg_table[i] = entries[i];
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = pick_gap(recv_calm);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            // hold off long enough for the block to back up into its input
            if (!held_off && taken_count >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [31:0] entries [SEGMENT_COUNT];
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(MODE_READ,  {OPT_REGISTER, 24'hFFFFE5}, $urandom);
        send(MODE_WRITE, {OPT_REGISTER, 24'h00001F}, 32'h8000_0000);
        send(MODE_READ,  {OPT_REGISTER, 24'hABCDFF}, '0);
        send(MODE_WRITE, {OPT_REGISTER, 24'h000000}, 32'h7FFF_FFFF);
        send(MODE_READ,  {OPT_IMMEDIATE, 24'hFF7FFF}, '0);
        send(MODE_READ,  {OPT_IMMEDIATE, 24'h008000}, '0);
        send(MODE_READ,  {OPT_IMMEDIATE, 24'h00FFFF}, '0);
        send(MODE_READ,  {OPT_IMMEDIATE, 24'h000000}, '0);
        send(MODE_WRITE, {OPT_IMMEDIATE, 24'h001234}, 32'hFFFF_FFFF);
        send(MODE_READ,  {OPT_UNKNOWN_LOW, 24'h000001}, '0);
        send(MODE_WRITE, {OPT_UNKNOWN_HIGH, 24'hFFFFFF}, 32'hFFFF_FFFF);
        // every segment is still invalid after reset
        send(MODE_READ,  memory_operand(5'd5, 16'h0000), '0);

        wait_idle();
        entries = '{32'h0100_0010, 32'hFFFE_FFFF, 32'h0000_0003, 32'h0040_0004,
                    32'hFFFF_FFFF, 32'h0000_0000, 32'hF000_FFFF, 32'h1234_0100};
        load_segment_table(entries);

        send(MODE_WRITE, memory_operand(5'd5, 16'h0000), 32'hDEAD_BEEF);
        send(MODE_READ,  memory_operand(5'd5, 16'h0000), '0);
        send(MODE_WRITE, memory_operand(5'd5, 16'h000C), 32'h0123_4567);
        send(MODE_READ,  memory_operand(5'd5, 16'h000D), '0);
        send(MODE_WRITE, {OPT_REGISTER, 24'h000006}, 32'h0001_0010);
        // base 0xFFFE: the word wraps past the top of memory
        send(MODE_WRITE, memory_operand(5'd6, 16'hFFF0), 32'hA5A5_5A5A);
        send(MODE_READ,  memory_operand(LAR_INDEX, 16'h0000), '0);
        send(MODE_WRITE, {OPT_REGISTER, 24'h000007}, 32'h0002_0000);
        send(MODE_WRITE, memory_operand(5'd7, 16'h0000), $urandom);
        send(MODE_READ,  memory_operand(5'd5, 16'hFFFF), '0);
        send(MODE_WRITE, {OPT_REGISTER, 24'h000008}, 32'h0006_1000);
        // base plus offset wraps modulo 2^16
        send(MODE_WRITE, memory_operand(5'd8, 16'h1000), $urandom);
        send(MODE_READ,  memory_operand(5'd8, 16'h1000), '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                foreach (entries[i]) entries[i] = pick_segment_entry();
                load_segment_table(entries);
            end
            repeat (PHASE_ITEMS) push_item(rand_request());
        end

        wait_idle();
        if (sb.errors == 0)
            $display("segmented_operand_access_unit_tb passed");
        else
            $display("segmented_operand_access_unit_tb failed");
        $finish;
    end

endmodule

### segmented_operand_access_unit.f
src/soau_pkg.sv
src/soau_ctrl.sv
src/soau_dp.sv
src/segmented_operand_access_unit.sv
dv/segmented_operand_access_unit_tb.sv
